>>> hdl/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types and constants for the tick / nanosecond converter.
// ----------------------------------------------------------------------------
package ttc_pkg;

	localparam logic [31:0] NS_PER_SEC   = 32'd1000000000;
	localparam logic [31:0] NS_ROUND_UP  = 32'd999999999;
	localparam logic [63:0] POS_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN      = 64'h8000_0000_0000_0000;

	localparam int unsigned QUOT_CELLS = 64;
	localparam int unsigned FRAC_CELLS = 32;

	localparam logic [1:0] REG_TICK_FREQ = 2'd0;
	localparam logic [1:0] REG_MAX_TICK  = 2'd1;
	localparam logic [1:0] REG_MAX_NS    = 2'd2;

	localparam logic OP_TICK_TO_NS = 1'b0;
	localparam logic OP_NS_TO_TICK = 1'b1;

	// one item travelling down a divider chain
	typedef struct packed {
		logic        op;
		logic        neg;
		logic        sat;
		logic [63:0] secs;
		logic [63:0] acc;   // dividend bits out at the top, quotient bits in at the bottom
		logic [31:0] rem;
	} ttc_item_t;

endpackage

>>> hdl/ttc_div_cell.sv
// ----------------------------------------------------------------------------
// ttc_div_cell
// One restoring-division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
module ttc_div_cell import ttc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [31:0] freq,
	input  logic        in_valid,
	input  ttc_item_t   in_item,
	output logic        out_valid,
	output ttc_item_t   out_item
);

	logic [31:0] divisor;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;
	ttc_item_t   nxt;
	logic        valid_q;
	ttc_item_t   item_q;

	always_comb begin
		divisor = (in_item.op == OP_NS_TO_TICK) ? NS_PER_SEC : freq;
		trial   = {in_item.rem, in_item.acc[63]};
		diff    = trial - {1'b0, divisor};
		ge      = (trial >= {1'b0, divisor});
		nxt     = in_item;
		nxt.acc = {in_item.acc[62:0], ge};
		nxt.rem = ge ? diff[31:0] : trial[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

>>> hdl/tick_time_conversion_core.sv
// ----------------------------------------------------------------------------
// tick_time_conversion_core
// Signed tick <-> nanosecond converter with saturation limits.
// ----------------------------------------------------------------------------
// Fully pipelined: one item accepted per cycle while the output is not stalled.
// The pipeline is the two cell chains of the divider (64 cells for whole
// seconds, 32 for the fraction) plus entry, remainder-multiply, fraction
// dividend, seconds-multiply, sum and output stages. A stalled output holds
// the whole pipeline. Registers: tick_frequency at 0x00, max_tick_magnitude
// at 0x08, max_ns_magnitude at 0x10; a frequency of zero acts as one.
module tick_time_conversion_core import ttc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] value_in
	input  logic        s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] value_out
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [31:0] freq_q;
	logic [62:0] max_tick_q;
	logic [62:0] max_ns_q;
	logic [31:0] freq_eff;
	logic        en;

	assign pready   = 1'b1;
	assign freq_eff = (freq_q == 32'd0) ? 32'd1 : freq_q;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q     <= 32'd19200000;
			max_tick_q <= 63'd9223372036;
			max_ns_q   <= 63'd9223372036;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:3])
				REG_TICK_FREQ: freq_q     <= pwdata[31:0];
				REG_MAX_TICK:  max_tick_q <= pwdata[62:0];
				REG_MAX_NS:    max_ns_q   <= pwdata[62:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_TICK_FREQ: prdata = {32'd0, freq_q};
			REG_MAX_TICK:  prdata = {1'b0, max_tick_q};
			REG_MAX_NS:    prdata = {1'b0, max_ns_q};
			default:       prdata = 64'd0;
		endcase
	end

	// entry
	logic [63:0] mag_in;
	logic [62:0] limit_in;
	logic        valid_s1;
	ttc_item_t   item_s1;

	assign mag_in   = s_tdata[63] ? (64'd0 - s_tdata) : s_tdata;
	assign limit_in = (s_tuser == OP_NS_TO_TICK) ? max_ns_q : max_tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.op   <= s_tuser;
			item_s1.neg  <= s_tdata[63];
			item_s1.sat  <= (mag_in > {1'b0, limit_in});
			item_s1.secs <= 64'd0;
			item_s1.acc  <= mag_in;
			item_s1.rem  <= 32'd0;
		end
	end

	// whole-second chain
	logic      qv [0:QUOT_CELLS];
	ttc_item_t qi [0:QUOT_CELLS];

	assign qv[0] = valid_s1;
	assign qi[0] = item_s1;

	for (genvar g = 0; g < QUOT_CELLS; g++) begin : g_quot
		ttc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.freq     (freq_eff),
			.in_valid (qv[g]),
			.in_item  (qi[g]),
			.out_valid(qv[g+1]),
			.out_item (qi[g+1])
		);
	end

	// remainder times multiplier
	ttc_item_t q_last;
	ttc_item_t q_next;
	logic [31:0] mult_q;
	logic        valid_s2;
	logic [63:0] prod_s2;
	ttc_item_t   item_s2;

	assign q_last = qi[QUOT_CELLS];
	assign mult_q = (q_last.op == OP_NS_TO_TICK) ? freq_eff : NS_PER_SEC;

	always_comb begin
		q_next      = q_last;
		q_next.secs = q_last.acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= qv[QUOT_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= q_last.rem * mult_q;
			item_s2 <= q_next;
		end
	end

	// fraction dividend
	logic [63:0] dividend;
	ttc_item_t   s3_next;
	logic        valid_s3;
	ttc_item_t   item_s3;

	assign dividend = prod_s2 + ((item_s2.op == OP_NS_TO_TICK) ?
		{32'd0, NS_ROUND_UP} : 64'd0);

	always_comb begin
		s3_next     = item_s2;
		s3_next.acc = {dividend[31:0], 32'd0};
		s3_next.rem = dividend[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3 <= s3_next;
		end
	end

	// fraction chain
	logic      fv [0:FRAC_CELLS];
	ttc_item_t fi [0:FRAC_CELLS];

	assign fv[0] = valid_s3;
	assign fi[0] = item_s3;

	for (genvar g = 0; g < FRAC_CELLS; g++) begin : g_frac
		ttc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.freq     (freq_eff),
			.in_valid (fv[g]),
			.in_item  (fi[g]),
			.out_valid(fv[g+1]),
			.out_item (fi[g+1])
		);
	end

	// whole seconds times multiplier, two halves
	ttc_item_t f_last;
	logic [31:0] mult_f;
	logic        valid_s4;
	logic [63:0] phi_s4;
	logic [63:0] plo_s4;
	logic [31:0] frac_s4;
	logic        neg_s4;
	logic        sat_s4;

	assign f_last = fi[FRAC_CELLS];
	assign mult_f = (f_last.op == OP_NS_TO_TICK) ? freq_eff : NS_PER_SEC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= fv[FRAC_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s4  <= f_last.secs[63:32] * mult_f;
			plo_s4  <= f_last.secs[31:0] * mult_f;
			frac_s4 <= f_last.acc[31:0];
			neg_s4  <= f_last.neg;
			sat_s4  <= f_last.sat;
		end
	end

	// sum and overflow
	logic [96:0] sum;
	logic        valid_s5;
	logic [62:0] mag_s5;
	logic        neg_s5;
	logic        sat_s5;

	assign sum = {1'b0, phi_s4, 32'd0} + {33'd0, plo_s4} + {65'd0, frac_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s5 <= sum[62:0];
			neg_s5 <= neg_s4;
			sat_s5 <= sat_s4 || (|sum[96:63]);
		end
	end

	// output register
	logic        out_valid_q;
	logic [63:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_s5) begin
				out_q <= neg_s5 ? NEG_MIN : POS_MAX;
			end else begin
				out_q <= neg_s5 ? (64'd0 - {1'b0, mag_s5}) : {1'b0, mag_s5};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// checks
	a_quot_rem: assert property (@(posedge clk) disable iff (!arst_n)
		qv[QUOT_CELLS] |-> (q_last.rem <
			((q_last.op == OP_NS_TO_TICK) ? NS_PER_SEC : freq_eff)))
		else $error("seconds remainder not below divisor");

	a_frac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fv[FRAC_CELLS] && (f_last.op == OP_TICK_TO_NS) |->
			(f_last.acc[31:0] < NS_PER_SEC))
		else $error("nanosecond fraction out of range");

	a_sat_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s5 && sat_s5 |=> (m_tdata == POS_MAX) || (m_tdata == NEG_MIN))
		else $error("saturated item not at an extreme");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s1) && $stable(qv[QUOT_CELLS]))
		else $error("pipeline moved during stall");

endmodule
